>>> design/upn_pkg.sv
// ---------------------------------------------------------------------------
// URL path normalizer package
// Shared payload structs, status codes, characters and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package upn_pkg;

  // Default capacity of the normalized path store, in bytes.
  localparam int OUT_CAP_DEF = 256;

  // Command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPT  = 2'd0;
  localparam logic [1:0] ST_DONE_OK = 2'd1;
  localparam logic [1:0] ST_ESCAPE  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Path characters.
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // One input beat.
  typedef struct packed {
    logic       cmd;
    logic [7:0] path_byte;
    logic       is_last;
    logic [7:0] read_index;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] path_length;
    logic [7:0] read_byte;
  } out_t;

endpackage

`default_nettype wire

>>> design/url_path_normalizer_core.sv
// ---------------------------------------------------------------------------
// URL path normalizer core
// Sequence: a read goes through S_READ; a push goes through S_PUSH, then
// S_CHAR or, for a slash, S_CLOSE and one S_BACK step per stored byte that a
// ".." segment backs over, then S_LAST; a last byte closes in S_FINISH.
// Throughput: one beat at a time; busy stays high until the result is issued,
// which the receiver cannot stall.
// Reset (rst_n, synchronous) clears the path state; the store keeps data.
// ---------------------------------------------------------------------------
`default_nettype none

module url_path_normalizer_core #(
  parameter int OUT_CAP = upn_pkg::OUT_CAP_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire upn_pkg::in_t in_data,
  output logic              out_valid,
  output upn_pkg::out_t     out_data
);

  localparam int AW = $clog2(OUT_CAP);
  localparam int SW = $clog2(OUT_CAP + 1);
  localparam int LW = SW + 1;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_PUSH   = 3'd2;
  localparam logic [2:0] S_CHAR   = 3'd3;
  localparam logic [2:0] S_LAST   = 3'd4;
  localparam logic [2:0] S_CLOSE  = 3'd5;
  localparam logic [2:0] S_BACK   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  // Control state.
  logic [2:0]  state_r, state_nxt;
  logic [SW-1:0] kept_r, kept_nxt;
  logic [SW-1:0] seg_r, seg_nxt;
  logic        dots_r, dots_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [7:0]    ch_r;
  logic          last_r;
  logic          rd_ok_r;
  logic [7:0]    rdata_r;
  upn_pkg::out_t out_r, out_nxt;

  // Store ports.
  logic [7:0]    store_mem [OUT_CAP];
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;

  // Shared address arithmetic.
  logic [SW-1:0] kept_m1, kept_m2;
  logic [LW-1:0] char_pos, close_sum, grow_len;
  logic          accept;

  assign accept   = start && (state_r == S_IDLE);
  assign kept_m1  = kept_r - SW'(1);
  assign kept_m2  = kept_r - SW'(2);
  assign char_pos = {1'b0, kept_r} + {1'b0, seg_r} + LW'(1);
  assign grow_len = char_pos;
  assign close_sum = char_pos + LW'(1);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    rdata_r <= store_mem[raddr];
  end

  // Store read address selection.
  always_comb begin
    case (state_r)
      S_IDLE:  raddr = AW'(in_data.read_index);
      S_BACK:  raddr = kept_m2[AW-1:0];
      default: raddr = kept_m1[AW-1:0];
    endcase
  end

  // Sequencer: one step of the path update per cycle.
  always_comb begin
    state_nxt     = state_r;
    kept_nxt      = kept_r;
    seg_nxt       = seg_r;
    dots_nxt      = dots_r;
    err_nxt       = err_r;
    fin_nxt       = fin_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = char_pos[AW-1:0];
    wdata         = ch_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          fin_nxt   = 1'b0;
          state_nxt = (in_data.cmd == upn_pkg::CMD_READ) ? S_READ : S_PUSH;
        end
      end

      S_READ: begin
        out_valid_nxt       = 1'b1;
        out_nxt.status      = upn_pkg::ST_ACCEPT;
        out_nxt.path_length = 8'd0;
        out_nxt.read_byte   = rd_ok_r ? rdata_r : 8'd0;
        state_nxt           = S_IDLE;
      end

      S_PUSH: begin
        if (err_r != upn_pkg::ST_ACCEPT) begin
          state_nxt = S_LAST;
        end else if (ch_r == upn_pkg::CH_SLASH) begin
          state_nxt = S_CLOSE;
        end else if (seg_r == '0) begin
          // A new segment opens with its slash; the byte follows next cycle.
          we        = ({1'b0, kept_r} < LW'(OUT_CAP));
          waddr     = kept_r[AW-1:0];
          wdata     = upn_pkg::CH_SLASH;
          state_nxt = S_CHAR;
        end else begin
          state_nxt = S_CHAR;
        end
      end

      S_CHAR: begin
        // Store the segment byte speculatively and count it.
        if (seg_r < SW'(OUT_CAP)) begin
          we      = (char_pos < LW'(OUT_CAP));
          seg_nxt = seg_r + SW'(1);
        end
        if (ch_r != upn_pkg::CH_DOT) begin
          dots_nxt = 1'b0;
        end
        state_nxt = S_LAST;
      end

      S_LAST: begin
        if (last_r) begin
          fin_nxt   = 1'b1;
          state_nxt = S_CLOSE;
        end else begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = upn_pkg::ST_ACCEPT;
          out_nxt.path_length = 8'd0;
          out_nxt.read_byte   = 8'd0;
          state_nxt           = S_IDLE;
        end
      end

      S_CLOSE: begin
        // Close the current segment; a ".." backs up through the store.
        seg_nxt   = '0;
        dots_nxt  = 1'b1;
        state_nxt = fin_r ? S_FINISH : S_LAST;
        if (seg_r == '0 || err_r != upn_pkg::ST_ACCEPT) begin
          state_nxt = fin_r ? S_FINISH : S_LAST;
        end else if (seg_r == SW'(1) && dots_r) begin
          state_nxt = fin_r ? S_FINISH : S_LAST;
        end else if (seg_r == SW'(2) && dots_r) begin
          if (kept_r == '0) begin
            err_nxt = upn_pkg::ST_ESCAPE;
          end else begin
            state_nxt = S_BACK;
          end
        end else if (close_sum > LW'(OUT_CAP)) begin
          err_nxt = upn_pkg::ST_TOO_LONG;
        end else begin
          kept_nxt = grow_len[SW-1:0];
        end
      end

      S_BACK: begin
        // One stored byte per cycle until the previous slash is removed.
        kept_nxt = kept_m1;
        if (rdata_r == upn_pkg::CH_SLASH || kept_r == SW'(1)) begin
          state_nxt = fin_r ? S_FINISH : S_LAST;
        end
      end

      S_FINISH: begin
        out_valid_nxt     = 1'b1;
        out_nxt.read_byte = 8'd0;
        if (err_r != upn_pkg::ST_ACCEPT) begin
          out_nxt.status      = err_r;
          out_nxt.path_length = 8'd0;
        end else begin
          out_nxt.status = upn_pkg::ST_DONE_OK;
          if (kept_r == '0) begin
            // Empty result becomes the root path.
            we                  = 1'b1;
            waddr               = '0;
            wdata               = upn_pkg::CH_SLASH;
            out_nxt.path_length = 8'd1;
          end else begin
            out_nxt.path_length = 8'(kept_r);
          end
        end
        kept_nxt  = '0;
        seg_nxt   = '0;
        dots_nxt  = 1'b1;
        err_nxt   = upn_pkg::ST_ACCEPT;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kept_r      <= '0;
      seg_r       <= '0;
      dots_r      <= 1'b1;
      err_r       <= upn_pkg::ST_ACCEPT;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      seg_r       <= seg_nxt;
      dots_r      <= dots_nxt;
      err_r       <= err_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Beat capture and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r    <= in_data.path_byte;
      last_r  <= in_data.is_last;
      rd_ok_r <= (32'(in_data.read_index) < OUT_CAP);
    end
    out_r <= out_nxt;
  end

  // The result strobe is never held high back to back.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  // The kept length always leaves room inside the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, kept_r} < LW'(OUT_CAP)))
    else $error("kept length reached the store capacity");

  // A recorded error holds until the path finishes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != upn_pkg::ST_ACCEPT && state_r != S_FINISH) |=> (err_r == $past(err_r)))
    else $error("error code changed mid-path");

  // A result is issued only on the way back to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result issued while the sequencer is active");

endmodule

`default_nettype wire

>>> tb/url_path_normalizer_core_test.sv
// ---------------------------------------------------------------------------
// URL path normalizer core testbench
// Feeds decoded path bytes and store reads through the start/busy port and
// checks every result beat against an in-bench predictor of the normalizer.
// Directed paths cover dot segments, escapes, empty results and capacity
// limits. Random well-formed paths with interleaved reads and some noise
// follow, with and without random sender gaps.
// ---------------------------------------------------------------------------
`default_nettype none

module url_path_normalizer_core_test;
  import upn_pkg::*;

  localparam int STORE_DEPTH = OUT_CAP_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  url_path_normalizer_core #(
    .OUT_CAP(STORE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Results predicted for accepted beats, oldest first.
  out_t pending_results[$];
  int mismatch_count = 0;
  int beats_sent = 0;
  bit gaps_on = 1'b1;

  // Predictor state: store image, which entries hold data, and path state.
  logic [7:0] store_img [STORE_DEPTH];
  bit store_set [STORE_DEPTH];
  logic [8:0] kept_len = '0;
  logic [8:0] seg_len = '0;
  bit seg_dots = 1'b1;
  // ST_ACCEPT here means that no error has been seen in the current path.
  logic [1:0] path_err = ST_ACCEPT;

  // Count one mismatch, printing its line for the first 60 only.
  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 60) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Writes beyond the store capacity are dropped.
  function automatic void store_byte(input int pos, input logic [7:0] value);
    if (pos < STORE_DEPTH) begin
      store_img[pos] = value;
      store_set[pos] = 1'b1;
    end
  endfunction

  // Close the segment in progress: drop it, back up over the previous one,
  // commit it to the normalized length, or record an escape or length error.
  function automatic void end_segment();
    int n;
    bit dots;
    n = int'(seg_len);
    dots = seg_dots;
    seg_len = '0;
    seg_dots = 1'b1;
    if (n == 0 || path_err != ST_ACCEPT) return;
    if (n == 1 && dots) return;
    if (n == 2 && dots) begin
      if (kept_len == 0) begin
        path_err = ST_ESCAPE;
        return;
      end
      while (kept_len > 0 && store_img[kept_len - 1] != CH_SLASH) kept_len--;
      if (kept_len > 0) kept_len--;
      return;
    end
    // One store slot always stays free.
    if (int'(kept_len) + 2 + n > STORE_DEPTH) begin
      path_err = ST_TOO_LONG;
    end else begin
      kept_len = 9'(int'(kept_len) + 1 + n);
    end
  endfunction

  // Work out the result of one accepted beat and update the predictor.
  function automatic out_t normalize_step(input in_t beat);
    out_t res;
    res = '0;
    if (beat.cmd == CMD_READ) begin
      res.read_byte = store_img[beat.read_index];
      return res;
    end
    if (path_err == ST_ACCEPT) begin
      if (beat.path_byte == CH_SLASH) begin
        end_segment();
      end else begin
        // Segment bytes land in the store as soon as they arrive.
        if (seg_len == 0) store_byte(int'(kept_len), CH_SLASH);
        if (seg_len < STORE_DEPTH) begin
          store_byte(int'(kept_len) + 1 + int'(seg_len), beat.path_byte);
          seg_len++;
        end
        if (beat.path_byte != CH_DOT) seg_dots = 1'b0;
      end
    end
    if (beat.is_last) begin
      end_segment();
      if (path_err != ST_ACCEPT) begin
        res.status = path_err;
      end else begin
        // An empty result becomes a single slash.
        if (kept_len == 0) begin
          store_byte(0, CH_SLASH);
          kept_len = 9'd1;
        end
        res.status = ST_DONE_OK;
        res.path_length = kept_len[7:0];
      end
      kept_len = '0;
      seg_len = '0;
      seg_dots = 1'b1;
      path_err = ST_ACCEPT;
    end
    return res;
  endfunction

  // Send one beat, with a random gap first when gaps are on, and record its
  // expected result. Start stays high from one beat to the next unless a gap is taken.
  task automatic send_beat(input in_t beat);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
    pending_results.push_back(normalize_step(beat));
    beats_sent++;
  endtask

  task automatic send_push(input logic [7:0] ch, input bit last);
    in_t beat;
    beat.cmd = CMD_PUSH;
    beat.path_byte = ch;
    beat.is_last = last;
    beat.read_index = 8'($urandom);
    send_beat(beat);
  endtask

  // Pick a store entry that already holds data, starting at a random point.
  function automatic int pick_written_index();
    int base;
    base = $urandom_range(0, STORE_DEPTH - 1);
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (store_set[(base + k) % STORE_DEPTH]) return (base + k) % STORE_DEPTH;
    end
    return -1;
  endfunction

  // Read one stored byte; a negative index picks a written one at random.
  // Entries never written are not read.
  task automatic send_read(input int idx);
    in_t beat;
    if (idx < 0) idx = pick_written_index();
    if (idx < 0 || !store_set[idx]) return;
    beat.cmd = CMD_READ;
    beat.path_byte = 8'($urandom);
    beat.is_last = 1'($urandom);
    beat.read_index = idx[7:0];
    send_beat(beat);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_push(s[i], i == s.len() - 1);
  endtask

  // Push a whole path, the last byte flagged, with optional reads between.
  task automatic send_bytes(input logic [7:0] q[$], input bit with_reads);
    for (int i = 0; i < q.size(); i++) begin
      if (with_reads && $urandom_range(0, 6) == 0) send_read(-1);
      send_push(q[i], i == q.size() - 1);
    end
  endtask

  // Append a segment body of n bytes: letters, dots and arbitrary bytes.
  function automatic void add_word(ref logic [7:0] q[$], input int n);
    logic [7:0] ch;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: ch = CH_DOT;
        2, 3, 4: begin
          ch = 8'($urandom_range(0, 255));
          if (ch == CH_SLASH) ch = 8'h00;
        end
        default: ch = 8'h61 + 8'($urandom_range(0, 25));
      endcase
      q.push_back(ch);
    end
  endfunction

  // Short paths covering each kind of segment and the accept, done and escape statuses.
  task automatic test_directed_paths();
    send_text("/");
    send_text("x");
    send_text("a//./b");
    send_text("/..");
    send_text("a/..");
    // A NUL byte and an all-ones byte are ordinary segment characters.
    send_push(8'h00, 1'b0);
    send_push(8'hFF, 1'b1);
    // Bytes after an escape are ignored until the last one reports it.
    send_text("../q");
    send_read(0);
    send_read(1);
    send_read(2);
  endtask

  // Paths at and beyond the store capacity, and a long backup.
  task automatic test_capacity_limits();
    logic [7:0] q[$];
    // A single segment that exactly fits, then one byte more.
    for (int n = STORE_DEPTH - 2; n <= STORE_DEPTH - 1; n++) begin
      q = {CH_SLASH};
      for (int i = 0; i < n; i++) q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      send_bytes(q, 1'b0);
    end
    // A segment longer than the store: its length saturates.
    q = {CH_SLASH};
    add_word(q, STORE_DEPTH + 44);
    send_bytes(q, 1'b0);
    send_read(0);
    send_read(STORE_DEPTH - 1);
    // A ".." backs up over a long stored segment.
    q = {CH_SLASH};
    for (int i = 0; i < 200; i++) q.push_back(8'h61 + 8'($urandom_range(0, 25)));
    q = {q, CH_SLASH, CH_DOT, CH_DOT, CH_SLASH, 8'h7A};
    send_bytes(q, 1'b1);
    // Five segments fill the store; one more overflows at a segment boundary.
    q = {};
    for (int s = 0; s < 5; s++) begin
      q.push_back(CH_SLASH);
      for (int i = 0; i < 50; i++) q.push_back(8'h61 + 8'($urandom_range(0, 25)));
    end
    q = {q, CH_SLASH, 8'h62};
    send_bytes(q, 1'b0);
  endtask

  // One well-formed path with random segments and reads between its bytes.
  task automatic send_random_path();
    logic [7:0] q[$];
    int segs;
    segs = $urandom_range(0, 6);
    if ($urandom_range(0, 4) != 0) q.push_back(CH_SLASH);
    for (int s = 0; s < segs; s++) begin
      case ($urandom_range(0, 9))
        0: q.push_back(CH_DOT);
        1, 2: q = {q, CH_DOT, CH_DOT};
        3: ;
        4: add_word(q, $urandom_range(20, 90));
        5: for (int i = 0; i < $urandom_range(3, 4); i++) q.push_back(CH_DOT);
        default: add_word(q, $urandom_range(1, 8));
      endcase
      if (s != segs - 1 || $urandom_range(0, 3) == 0) q.push_back(CH_SLASH);
    end
    if (q.size() == 0) q.push_back(CH_SLASH);
    send_bytes(q, 1'b1);
  endtask

  // Random paths, with raw byte runs and broken endings now and then.
  task automatic test_random_paths(input int beats, input bit gaps);
    int goal;
    goal = beats_sent + beats;
    gaps_on = gaps;
    while (beats_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < $urandom_range(1, 6); i++) begin
          send_push(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end else begin
        send_random_path();
      end
    end
    gaps_on = 1'b1;
  endtask

  // Hold the sender off mid-path until every result is in, then finish.
  task automatic test_pause_until_drained();
    send_push(CH_SLASH, 1'b0);
    send_push(8'h61, 1'b0);
    send_push(8'h62, 1'b0);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    send_read(-1);
    send_text("c/de");
  endtask

  // Compare each result beat with the oldest prediction, field by field.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing expected: status=%0d len=%0d byte=%h",
          out_data.status, out_data.path_length, out_data.read_byte));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          flag_error($sformatf("status %0d, expected %0d", out_data.status, want.status));
        end
        if (out_data.path_length !== want.path_length) begin
          flag_error($sformatf("path_length %0d, expected %0d",
            out_data.path_length, want.path_length));
        end
        if (out_data.read_byte !== want.read_byte) begin
          flag_error($sformatf("read_byte %h, expected %h",
            out_data.read_byte, want.read_byte));
        end
      end
    end
  end

  // End the run if it hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_img[i] = '0;
      store_set[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_paths();
    test_capacity_limits();
    test_random_paths(120, 1'b1);
    test_pause_until_drained();
    test_random_paths(100, 1'b0);
    test_random_paths(50, 1'b1);

    // Drain the last results, then keep watching for strays before the summary.
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (12) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
